### design/deq_pkg.sv
// Shared types, sizes and a ring index helper for the double-ended queue unit.
package deq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int DATA_W = 32;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_DUMP       = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_DUMP
    } state_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } deq_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } deq_rd_t;

    function automatic logic [IDX_W-1:0] ring_slot(
        input logic [IDX_W-1:0] front,
        input logic [IDX_W-1:0] offset
    );
        logic [IDX_W:0] sum;
        begin
            sum = {1'b0, front} + {1'b0, offset};
            if (sum >= (IDX_W+1)'(DEPTH))
            begin
                sum = sum - (IDX_W+1)'(DEPTH);
            end
            return sum[IDX_W-1:0];
        end
    endfunction

endpackage

### design/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: control, ring indexes and result register.
//
//   port group   direction  qualifier      contents
//   command      in         start & !busy  opcode, push_value
//   result       out        done           status, out_value, last
//
// A push or a rejected command gives its result in the cycle after acceptance;
// busy stays low, so the next command may follow at once.
// A pop reads its entry into the store's read data register, then S_POP moves it to the result register.
// A dump holds busy until its last entry is read and streams one entry per cycle from the read port.
// Reset clears front index and count; the store itself is not cleared.
// The receiver cannot stall: each result stands on the ports for one cycle.
module double_ended_queue_unit
    import deq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               opcode,
    input  logic signed [DATA_W-1:0] push_value,
    output logic                     done,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] out_value,
    output logic                     last
);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               done_reg, done_next;
    status_t            status_reg, status_next;
    logic [DATA_W-1:0]  value_reg, value_next;
    logic               last_reg, last_next;

    deq_wr_t            wr;
    deq_rd_t            rd;
    logic [DATA_W-1:0]  rd_data;

    logic               accept;
    logic               is_empty;
    logic               is_full;
    logic               dump_last;
    logic [IDX_W-1:0]   back_off;

    deq_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    assign accept    = start && (state_reg == S_IDLE);
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == FULL_COUNT);
    assign back_off  = count_reg[IDX_W-1:0] - IDX_W'(1);
    assign dump_last = (({1'b0, idx_reg} + CNT_W'(1)) == count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        last_reg   <= last_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        done_next   = 1'b0;
        status_next = ST_OK;
        value_next  = '0;
        last_next   = 1'b1;
        wr.en       = 1'b0;
        wr.addr     = ring_slot(front_reg, count_reg[IDX_W-1:0]);
        wr.data     = push_value;
        rd.en       = 1'b0;
        rd.addr     = ring_slot(front_reg, '0);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        OP_PUSH_BACK, OP_PUSH_FRONT:
                        begin
                            done_next = 1'b1;
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr.en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                if (opcode == OP_PUSH_FRONT)
                                begin
                                    front_next = (front_reg == '0) ? LAST_SLOT
                                                 : front_reg - IDX_W'(1);
                                    wr.addr    = front_next;
                                end
                            end
                        end
                        OP_POP_BACK, OP_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd.en      = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                                state_next = S_POP;
                                if (opcode == OP_POP_BACK)
                                begin
                                    rd.addr = ring_slot(front_reg, back_off);
                                end
                                else
                                begin
                                    front_next = ring_slot(front_reg, IDX_W'(1));
                                end
                            end
                        end
                        OP_DUMP:
                        begin
                            if (is_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd.en      = 1'b1;
                                idx_next   = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                done_next  = 1'b1;
                value_next = rd_data;
                state_next = S_IDLE;
            end
            S_DUMP:
            begin
                done_next  = 1'b1;
                value_next = rd_data;
                last_next  = dump_last;
                if (dump_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    rd.en    = 1'b1;
                    rd.addr  = ring_slot(front_reg, idx_next);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign out_value = value_reg;
    assign last      = last_reg;

endmodule

### design/deq_store.sv
// Ring store: one write port, one read port with registered read data.
module deq_store
    import deq_pkg::*;
(
    input  logic                clk,
    input  deq_wr_t             wr,
    input  deq_rd_t             rd,
    output logic [DATA_W-1:0]   rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
